[rtl/core/pst_pkg.sv]
// Package: defaults, command and status codes and sequencer states of the subscription table.
`default_nettype none
package pst_pkg;

  localparam int unsigned NumMsgIdsDefault = 64;
  localparam int unsigned MaxSubsDefault   = 8;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned MsgIdW  = 16;
  localparam int unsigned ModIdW  = 8;
  localparam int unsigned StatusW = 3;

  typedef enum logic [CmdW-1:0] {
    CmdSubscribe   = 2'd0,
    CmdUnsubscribe = 2'd1,
    CmdQuery       = 2'd2,
    CmdList        = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StInvalid  = 3'd1,
    StExists   = 3'd2,
    StFull     = 3'd3,
    StNotFound = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SCount,
    SScan,
    SMoveRd,
    SMoveWr
  } state_e;

endpackage
`default_nettype wire

[rtl/core/publish_subscribe_table_core.sv]
// Top level: subscription table of a message bus, count and entry memories with a sequencer.
//
// One command is taken at a time: start_i is accepted while busy_o is low. Every
// command gives its first result beat on done_o and the receiver cannot stall it.
// An invalid id answers in the cycle after acceptance. Otherwise the count memory
// is read first, and the list is then walked one entry memory read per cycle: a
// subscribe or query answers once it finds the module, and a search that finds
// nothing answers once all n entries are read (straight after the count read when
// n is 0). An unsubscribe that finds the module then moves the last entry into the
// freed slot (SMoveRd, SMoveWr). List emits its n beats on consecutive cycles (one
// empty beat when n is 0). The slowest command is an unsubscribe that finds the
// module in the last entry of a full list. busy_o falls with the final beat, so the
// next command may start on the cycle that beat is shown. After reset the count
// memory is cleared at one entry per cycle with busy_o high; the reserved id
// register may be written at any time.
`default_nettype none
module publish_subscribe_table_core #(
  parameter int unsigned NUM_MSG_IDS = pst_pkg::NumMsgIdsDefault,
  parameter int unsigned MAX_SUBS    = pst_pkg::MaxSubsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         reserved_msg_id_we_i,
  input  wire logic [pst_pkg::MsgIdW-1:0]   reserved_msg_id_i,
  input  wire logic                         start_i,
  input  wire logic [pst_pkg::CmdW-1:0]     cmd_i,
  input  wire logic [pst_pkg::MsgIdW-1:0]   msg_id_i,
  input  wire logic [pst_pkg::ModIdW-1:0]   module_id_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [pst_pkg::StatusW-1:0]       status_o,
  output logic                              is_member_o,
  output logic                              entry_valid_o,
  output logic [pst_pkg::ModIdW-1:0]        subscriber_o,
  output logic                              last_o
);

  localparam int unsigned IdW    = (NUM_MSG_IDS > 1) ? $clog2(NUM_MSG_IDS) : 1;
  localparam int unsigned Depth  = NUM_MSG_IDS * MAX_SUBS;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW   = $clog2(MAX_SUBS + 1);

  logic [pst_pkg::ModIdW-1:0] store_mem [Depth];
  logic [CntW-1:0]            cnt_mem   [NUM_MSG_IDS];

  pst_pkg::state_e state_q, state_d;

  logic [pst_pkg::MsgIdW-1:0] reserved_q;
  logic [IdW-1:0]             clr_q, clr_d;
  pst_pkg::cmd_e              cmd_q, cmd_d;
  logic [IdW-1:0]             id_q, id_d;
  logic [AddrW-1:0]           base_q, base_d;
  logic [pst_pkg::ModIdW-1:0] mod_q, mod_d;
  logic [CntW-1:0]            n_q, n_d;
  logic [CntW-1:0]            rd_idx_q, rd_idx_d;
  logic                       pend_q, pend_d;
  logic [CntW-1:0]            pend_idx_q, pend_idx_d;
  logic [CntW-1:0]            pos_q, pos_d;

  logic [IdW-1:0]             cnt_raddr;
  logic [CntW-1:0]            cnt_rdata_q;
  logic                       cnt_we;
  logic [IdW-1:0]             cnt_waddr;
  logic [CntW-1:0]            cnt_wdata;

  logic [AddrW-1:0]           store_raddr;
  logic [pst_pkg::ModIdW-1:0] store_rdata_q;
  logic                       store_we;
  logic [AddrW-1:0]           store_waddr;
  logic [pst_pkg::ModIdW-1:0] store_wdata;

  logic                       res_vld;
  pst_pkg::status_e           res_status;
  logic                       res_member;
  logic                       res_entry;
  logic [pst_pkg::ModIdW-1:0] res_sub;
  logic                       res_last;

  logic                       id_bad;
  logic                       hit;
  logic                       list_last;

  assign id_bad    = (msg_id_i == reserved_q) ||
                     (msg_id_i >= pst_pkg::MsgIdW'(NUM_MSG_IDS));
  assign hit       = pend_q && (store_rdata_q == mod_q);
  assign list_last = (pend_idx_q == CntW'(n_q - 1'b1));
  assign busy_o    = (state_q != pst_pkg::SIdle);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    base_d      = base_q;
    mod_d       = mod_q;
    n_d         = n_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    pos_d       = pos_q;
    cnt_raddr   = id_q;
    cnt_we      = 1'b0;
    cnt_waddr   = id_q;
    cnt_wdata   = '0;
    store_raddr = base_q + AddrW'(rd_idx_q);
    store_we    = 1'b0;
    store_waddr = base_q + AddrW'(n_q);
    store_wdata = mod_q;
    res_vld     = 1'b0;
    res_status  = pst_pkg::StOk;
    res_member  = 1'b0;
    res_entry   = 1'b0;
    res_sub     = '0;
    res_last    = 1'b1;

    case (state_q)
      pst_pkg::SClear: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IdW'(NUM_MSG_IDS - 1)) begin
          state_d = pst_pkg::SIdle;
        end
      end
      pst_pkg::SIdle: begin
        cnt_raddr = msg_id_i[IdW-1:0];
        if (start_i) begin
          cmd_d  = pst_pkg::cmd_e'(cmd_i);
          id_d   = msg_id_i[IdW-1:0];
          base_d = AddrW'(msg_id_i[IdW-1:0] * MAX_SUBS);
          mod_d  = module_id_i;
          if (id_bad) begin
            res_vld    = 1'b1;
            res_status = pst_pkg::StInvalid;
          end else begin
            state_d = pst_pkg::SCount;
          end
        end
      end
      pst_pkg::SCount: begin
        n_d      = cnt_rdata_q;
        rd_idx_d = '0;
        state_d  = pst_pkg::SScan;
      end
      pst_pkg::SScan: begin
        if (rd_idx_q < n_q) begin
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q;
          rd_idx_d   = rd_idx_q + 1'b1;
        end
        if (cmd_q == pst_pkg::CmdList) begin
          if (n_q == '0) begin
            res_vld = 1'b1;
            state_d = pst_pkg::SIdle;
          end else if (pend_q) begin
            res_vld   = 1'b1;
            res_entry = 1'b1;
            res_sub   = store_rdata_q;
            res_last  = list_last;
            if (list_last) begin
              state_d = pst_pkg::SIdle;
            end
          end
        end else if (hit) begin
          pos_d = pend_idx_q;
          case (cmd_q)
            pst_pkg::CmdSubscribe: begin
              res_vld    = 1'b1;
              res_status = pst_pkg::StExists;
              state_d    = pst_pkg::SIdle;
            end
            pst_pkg::CmdQuery: begin
              res_vld    = 1'b1;
              res_member = 1'b1;
              state_d    = pst_pkg::SIdle;
            end
            default: begin
              state_d = pst_pkg::SMoveRd;
            end
          endcase
        end else if (!pend_q && (rd_idx_q == n_q)) begin
          res_vld = 1'b1;
          state_d = pst_pkg::SIdle;
          case (cmd_q)
            pst_pkg::CmdSubscribe: begin
              if (n_q == CntW'(MAX_SUBS)) begin
                res_status = pst_pkg::StFull;
              end else begin
                store_we  = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = CntW'(n_q + 1'b1);
              end
            end
            pst_pkg::CmdUnsubscribe: begin
              res_status = pst_pkg::StNotFound;
            end
            default: begin
              res_status = pst_pkg::StOk;
            end
          endcase
        end
      end
      pst_pkg::SMoveRd: begin
        store_raddr = base_q + AddrW'(CntW'(n_q - 1'b1));
        state_d     = pst_pkg::SMoveWr;
      end
      pst_pkg::SMoveWr: begin
        store_we    = 1'b1;
        store_waddr = base_q + AddrW'(pos_q);
        store_wdata = store_rdata_q;
        cnt_we      = 1'b1;
        cnt_wdata   = CntW'(n_q - 1'b1);
        res_vld     = 1'b1;
        state_d     = pst_pkg::SIdle;
      end
      default: begin
        state_d = pst_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pst_pkg::SClear;
      clr_q      <= '0;
      reserved_q <= '0;
      pend_q     <= 1'b0;
      done_o     <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      done_o  <= res_vld;
      if (reserved_msg_id_we_i) begin
        reserved_q <= reserved_msg_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    id_q          <= id_d;
    base_q        <= base_d;
    mod_q         <= mod_d;
    n_q           <= n_d;
    rd_idx_q      <= rd_idx_d;
    pend_idx_q    <= pend_idx_d;
    pos_q         <= pos_d;
    status_o      <= res_status;
    is_member_o   <= res_member;
    entry_valid_o <= res_entry;
    subscriber_o  <= res_sub;
    last_o        <= res_last;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_rdata_q <= store_mem[store_raddr];
  end

endmodule
`default_nettype wire
